// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent, reset included.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/zcd_pkg.sv =====
// Types and constants of the central directory parser.
package zcd_pkg;

  localparam logic [31:0] SIG_CENTRAL = 32'h02014b50;
  localparam logic [15:0] ID_ZIP64    = 16'h0001;
  localparam logic [15:0] ID_AES      = 16'h9901;
  localparam logic [63:0] ALL_ONES32  = 64'h0000_0000_FFFF_FFFF;
  localparam logic [31:0] ATTR_DIR    = 32'h0000_0010;
  localparam logic [15:0] FLAG_CRYPT  = 16'h0001;
  localparam logic [17:0] HDR_LEN     = 18'd46;
  localparam int          QDEPTH      = 4;
  localparam int          QAW         = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    PH_HDR  = 3'b001,
    PH_BODY = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    ST_ENTRY   = 2'd0,
    ST_END     = 2'd1,
    ST_CORRUPT = 2'd2,
    ST_AES     = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        run_end;
    logic [15:0] gp_flags;
    logic [15:0] method;
    logic [15:0] dos_time;
    logic [31:0] crc;
    logic [63:0] packed_size;
    logic [63:0] plain_size;
    logic [63:0] local_offset;
    logic        is_dir;
    logic        encrypted;
    logic [1:0]  key_strength;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic result_t status_result(status_t st);
    result_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

endpackage

// ===== design/zip_central_dir_parser_unit.sv =====
// Zip central directory parser, one byte per cycle: each byte goes straight
// into the record parser, which updates the field captures and extra-record
// walk and forms its results in the same cycle; the results are registered
// and enter a four-word queue. A byte is taken every cycle while the queue
// has room for two words (a completed record on the last byte gives an entry
// and an end word), so the sustained rate is one byte per cycle as long as
// the output side drains one word per cycle.
module zip_central_dir_parser_unit import zcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        run_end,
  output logic [15:0] gp_flags,
  output logic [15:0] method,
  output logic [15:0] dos_time,
  output logic [31:0] crc,
  output logic [63:0] packed_size,
  output logic [63:0] plain_size,
  output logic [63:0] local_offset,
  output logic        is_dir,
  output logic        encrypted,
  output logic [1:0]  key_strength
);

  push_t   push;
  result_t head;
  logic    nearly_full;

  assign in_stall = nearly_full;

  zcd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (in_valid && !in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .push      (push)
  );

  zcd_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .pop         (!out_stall),
    .head        (head),
    .not_empty   (out_valid),
    .nearly_full (nearly_full)
  );

  assign status       = head.status;
  assign run_end      = head.run_end;
  assign gp_flags     = head.gp_flags;
  assign method       = head.method;
  assign dos_time     = head.dos_time;
  assign crc          = head.crc;
  assign packed_size  = head.packed_size;
  assign plain_size   = head.plain_size;
  assign local_offset = head.local_offset;
  assign is_dir       = head.is_dir;
  assign encrypted    = head.encrypted;
  assign key_strength = head.key_strength;

endmodule

// ===== design/zcd_parse.sv =====
// Byte parser: record state and result formation for one directory byte.
module zcd_parse import zcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output push_t      push
);

  phase_t      phase, phase_next;
  logic [17:0] record_pos, record_pos_next;
  logic [31:0] sig_shift, sig_shift_next;
  logic [15:0] hdr_flags, hdr_flags_next, hdr_method, hdr_method_next;
  logic [15:0] hdr_time, hdr_time_next;
  logic [31:0] hdr_crc, hdr_crc_next;
  logic [63:0] size_comp, size_comp_next, size_uncomp, size_uncomp_next;
  logic [63:0] offset_local, offset_local_next;
  logic [15:0] fname_len, fname_len_next, xfield_len, xfield_len_next;
  logic [15:0] comment_len, comment_len_next;
  logic [31:0] file_attr, file_attr_next;
  logic [7:0]  name_tail, name_tail_next;
  logic [31:0] sub_header, sub_header_next;
  logic [16:0] sub_pos, sub_pos_next;
  logic [1:0]  wide_slot, wide_slot_next;
  logic [63:0] wide_value, wide_value_next;
  logic        aes_seen, aes_seen_next, aes_bad, aes_bad_next;
  logic [7:0]  aes_level, aes_level_next;
  logic [15:0] aes_real_method, aes_real_method_next;
  logic        walk_off, walk_off_next;

  push_t       push_next;

  always_comb begin
    logic [17:0] pos, x, ex, pos_inc, total;
    logic [16:0] sp_inc, d;
    logic [15:0] sz, id, m;
    logic [2:0]  k;
    logic        sig_fail, dir;
    result_t     ent;

    phase_next = phase;
    record_pos_next = record_pos;
    sig_shift_next = sig_shift;
    hdr_flags_next = hdr_flags;
    hdr_method_next = hdr_method;
    hdr_time_next = hdr_time;
    hdr_crc_next = hdr_crc;
    size_comp_next = size_comp;
    size_uncomp_next = size_uncomp;
    offset_local_next = offset_local;
    fname_len_next = fname_len;
    xfield_len_next = xfield_len;
    comment_len_next = comment_len;
    file_attr_next = file_attr;
    name_tail_next = name_tail;
    sub_header_next = sub_header;
    sub_pos_next = sub_pos;
    wide_slot_next = wide_slot;
    wide_value_next = wide_value;
    aes_seen_next = aes_seen;
    aes_bad_next = aes_bad;
    aes_level_next = aes_level;
    aes_real_method_next = aes_real_method;
    walk_off_next = walk_off;
    push_next = '0;
    pos = record_pos;
    x = pos - HDR_LEN;
    ex = '0;
    pos_inc = pos + 18'd1;
    total = '0;
    sp_inc = '0;
    d = '0;
    sz = '0;
    id = '0;
    m = '0;
    k = '0;
    sig_fail = 1'b0;
    dir = 1'b0;
    ent = '0;

    if (phase == PH_DONE) begin
      if (last_byte) begin
        phase_next = PH_HDR;
        record_pos_next = '0;
      end
    end else begin
      if (phase == PH_HDR && record_pos == '0) begin
        sig_shift_next = '0; hdr_flags_next = '0; hdr_method_next = '0;
        hdr_time_next = '0; hdr_crc_next = '0; size_comp_next = '0;
        size_uncomp_next = '0; offset_local_next = '0; fname_len_next = '0;
        xfield_len_next = '0; comment_len_next = '0; file_attr_next = '0;
        name_tail_next = '0; sub_header_next = '0; sub_pos_next = '0;
        wide_slot_next = '0; wide_value_next = '0; aes_seen_next = 1'b0;
        aes_level_next = '0; aes_real_method_next = '0; aes_bad_next = 1'b0;
        walk_off_next = 1'b0;
      end
      if (pos < HDR_LEN) begin
        k = pos[2:0] - 3'd4;
        if (pos < 18'd4)
          sig_shift_next = sig_shift_next | (32'(data_byte) << {pos[1:0], 3'b000});
        else if (pos == 18'd8 || pos == 18'd9)
          hdr_flags_next = hdr_flags_next | (16'(data_byte) << {pos[0], 3'b000});
        else if (pos == 18'd10 || pos == 18'd11)
          hdr_method_next = hdr_method_next | (16'(data_byte) << {pos[0], 3'b000});
        else if (pos == 18'd12 || pos == 18'd13)
          hdr_time_next = hdr_time_next | (16'(data_byte) << {pos[0], 3'b000});
        else if (pos >= 18'd16 && pos < 18'd20)
          hdr_crc_next = hdr_crc_next | (32'(data_byte) << {pos[1:0], 3'b000});
        else if (pos >= 18'd20 && pos < 18'd24)
          size_comp_next = size_comp_next | (64'(data_byte) << {1'b0, k[1:0], 3'b000});
        else if (pos >= 18'd24 && pos < 18'd28)
          size_uncomp_next = size_uncomp_next | (64'(data_byte) << {1'b0, k[1:0], 3'b000});
        else if (pos == 18'd28 || pos == 18'd29)
          fname_len_next = fname_len_next | (16'(data_byte) << {pos[0], 3'b000});
        else if (pos == 18'd30 || pos == 18'd31)
          xfield_len_next = xfield_len_next | (16'(data_byte) << {pos[0], 3'b000});
        else if (pos == 18'd32 || pos == 18'd33)
          comment_len_next = comment_len_next | (16'(data_byte) << {pos[0], 3'b000});
        else if (pos >= 18'd38 && pos < 18'd42)
          file_attr_next = file_attr_next | (32'(data_byte) << {k[1:0] ^ 2'b10, 3'b000});
        else if (pos >= 18'd42 && pos < 18'd46)
          offset_local_next = offset_local_next |
                              (64'(data_byte) << {1'b0, k[1:0] ^ 2'b10, 3'b000});
        sig_fail = (pos == 18'd3) && (sig_shift_next != SIG_CENTRAL);
      end else if (x < 18'(fname_len)) begin
        name_tail_next = data_byte;
      end else if (x - 18'(fname_len) < 18'(xfield_len)) begin
        ex = x - 18'(fname_len);
        if (!walk_off) begin
          if (sub_pos == '0 && ex + 18'd4 > 18'(xfield_len)) begin
            walk_off_next = 1'b1;
          end else if (sub_pos < 17'd4) begin
            sub_header_next = (sub_pos == '0) ? 32'd0 : sub_header;
            sub_header_next = sub_header_next |
                              (32'(data_byte) << {sub_pos[1:0], 3'b000});
            sp_inc = sub_pos + 17'd1;
            sub_pos_next = sp_inc;
            sz = sub_header_next[31:16];
            if (sp_inc == 17'd4) begin
              if (ex + 18'd1 + 18'(sz) > 18'(xfield_len)) begin
                walk_off_next = 1'b1;
                sub_pos_next = '0;
              end else begin
                wide_slot_next = '0;
                wide_value_next = '0;
                if (sz == '0) sub_pos_next = '0;
              end
            end
          end else begin
            id = sub_header[15:0];
            sz = sub_header[31:16];
            d = sub_pos - 17'd4;
            if (id == ID_ZIP64) begin
              wide_value_next = wide_value | (64'(data_byte) << {d[2:0], 3'b000});
              if (d[2:0] == 3'd7) begin
                // fill the next all-ones field in order
                if (wide_slot == 2'd0 && size_uncomp == ALL_ONES32) begin
                  size_uncomp_next = wide_value_next;
                  wide_slot_next = 2'd1;
                end else if (wide_slot <= 2'd1 && size_comp == ALL_ONES32) begin
                  size_comp_next = wide_value_next;
                  wide_slot_next = 2'd2;
                end else if (wide_slot <= 2'd2 && offset_local == ALL_ONES32) begin
                  offset_local_next = wide_value_next;
                  wide_slot_next = 2'd3;
                end else begin
                  wide_slot_next = 2'd3;
                end
                wide_value_next = '0;
              end
            end else if (id == ID_AES && sz >= 16'd7 && !aes_bad) begin
              if (d == 17'd4) begin
                aes_seen_next = 1'b1;
                aes_level_next = data_byte;
                if (data_byte < 8'd1 || data_byte > 8'd3) aes_bad_next = 1'b1;
              end else if (d == 17'd5) begin
                aes_real_method_next = 16'(data_byte);
              end else if (d == 17'd6) begin
                aes_real_method_next = {data_byte, aes_real_method[7:0]};
              end
            end
            sp_inc = sub_pos + 17'd1;
            sub_pos_next = (sp_inc == 17'd4 + 17'(sz)) ? 17'd0 : sp_inc;
          end
        end
      end

      if (sig_fail) begin
        push_next.count = 2'd1;
        push_next.r0 = status_result(ST_END);
        phase_next = PH_DONE;
      end else begin
        record_pos_next = pos_inc;
        if (pos_inc >= HDR_LEN) phase_next = PH_BODY;
        total = HDR_LEN + 18'(fname_len_next) + 18'(xfield_len_next) +
                18'(comment_len_next);
        if (pos_inc >= HDR_LEN && pos_inc == total) begin
          if (aes_bad_next) begin
            push_next.count = 2'd1;
            push_next.r0 = status_result(ST_AES);
            phase_next = PH_DONE;
          end else begin
            m = aes_seen_next ? aes_real_method_next : hdr_method_next;
            dir = (fname_len_next != '0 && name_tail_next == 8'h2f) ||
                  ((file_attr_next & ATTR_DIR) != '0 && size_comp_next == '0 &&
                   size_uncomp_next == '0 && m == '0);
            ent.status = ST_ENTRY;
            ent.run_end = 1'b0;
            ent.gp_flags = hdr_flags_next;
            ent.method = m;
            ent.dos_time = hdr_time_next;
            ent.crc = hdr_crc_next;
            ent.packed_size = size_comp_next;
            ent.plain_size = size_uncomp_next;
            ent.local_offset = offset_local_next;
            ent.is_dir = dir;
            ent.encrypted = ((hdr_flags_next & FLAG_CRYPT) != '0) || aes_seen_next;
            ent.key_strength = aes_seen_next ? aes_level_next[1:0] : 2'd0;
            push_next.r0 = ent;
            push_next.count = 2'd1;
            record_pos_next = '0;
            phase_next = PH_HDR;
            if (last_byte) begin
              push_next.r1 = status_result(ST_END);
              push_next.count = 2'd2;
            end
          end
        end else if (last_byte) begin
          push_next.count = 2'd1;
          push_next.r0 = status_result((phase_next == PH_HDR) ? ST_END : ST_CORRUPT);
        end
      end
      if (last_byte) begin
        phase_next = PH_HDR;
        record_pos_next = '0;
      end
      // mark the last word of this byte
      if (push_next.count == 2'd2) push_next.r1.run_end = 1'b1;
      else if (push_next.count == 2'd1) push_next.r0.run_end = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    push.r0 <= push_next.r0;
    push.r1 <= push_next.r1;
    if (rst) begin
      phase <= PH_HDR;
      record_pos <= '0;
      push.count <= '0;
    end else begin
      push.count <= take ? push_next.count : 2'd0;
      if (take) begin
        phase <= phase_next;
        record_pos <= record_pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sig_shift <= sig_shift_next;
      hdr_flags <= hdr_flags_next;
      hdr_method <= hdr_method_next;
      hdr_time <= hdr_time_next;
      hdr_crc <= hdr_crc_next;
      size_comp <= size_comp_next;
      size_uncomp <= size_uncomp_next;
      offset_local <= offset_local_next;
      fname_len <= fname_len_next;
      xfield_len <= xfield_len_next;
      comment_len <= comment_len_next;
      file_attr <= file_attr_next;
      name_tail <= name_tail_next;
      sub_header <= sub_header_next;
      sub_pos <= sub_pos_next;
      wide_slot <= wide_slot_next;
      wide_value <= wide_value_next;
      aes_seen <= aes_seen_next;
      aes_bad <= aes_bad_next;
      aes_level <= aes_level_next;
      aes_real_method <= aes_real_method_next;
      walk_off <= walk_off_next;
    end
  end

endmodule

// ===== design/zcd_fifo.sv =====
// Result queue: takes up to two words a cycle, hands out one.
module zcd_fifo import zcd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  logic    pop,
  output result_t head,
  output logic    not_empty,
  output logic    nearly_full
);

  result_t          mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr, rd_ptr;
  logic [QAW:0]     count;
  logic             do_pop;

  assign do_pop = pop && (count != '0);
  assign head = mem[rd_ptr];
  assign not_empty = (count != '0);
  // leave room for the two words one byte can produce
  assign nearly_full = (count > (QAW+1)'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + QAW'(push.count);
      if (do_pop) rd_ptr <= rd_ptr + QAW'(1);
      count <= count + (QAW+1)'(push.count) - (QAW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.r0;
    if (push.count == 2'd2) mem[wr_ptr + QAW'(1)] <= push.r1;
  end

endmodule

// ===== design/zcd_check.sv =====
// Port checker for the central directory parser and its bind.
`include "assert_macros.svh"

module zcd_check import zcd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic        run_end,
  input logic [15:0] gp_flags,
  input logic [31:0] crc,
  input logic [63:0] packed_size
);

  `ASSERT_IMP(hold_word, out_valid && out_stall, ##1 (out_valid && $stable(status) && $stable(crc)))
  `ASSERT_NEXT(empty_after_rst, rst, !out_valid)
  `ASSERT_IMP(status_ends_run, out_valid && status != ST_ENTRY, run_end)
  `ASSERT_IMP(zero_fields, out_valid && status != ST_ENTRY, gp_flags == '0 && packed_size == '0)

endmodule

bind zip_central_dir_parser_unit zcd_check u_zcd_check (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .run_end     (run_end),
  .gp_flags    (gp_flags),
  .crc         (crc),
  .packed_size (packed_size)
);
